@@ design/kml_pkg.sv @@
// kml_pkg: shared types, constants and helpers for the keyword message lexer.
// Used by kml_front, kml_queue, kml_back, the top level and the checker.
`default_nettype none
package kml_pkg;

	localparam int POS_BITS = 32;
	localparam int MAX_RES  = 3;
	localparam int CNT_BITS = 2;
	localparam int Q_DEPTH  = 4;
	localparam int Q_AW     = $clog2(Q_DEPTH);
	localparam int Q_CW     = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	typedef logic [POS_BITS-1:0] pos_t;

	typedef enum logic [2:0] {
		K_ERROR   = 3'd0,
		K_EOS     = 3'd1,
		K_INT     = 3'd2,
		K_FLOAT   = 3'd3,
		K_IDENT   = 3'd4,
		K_KEYWORD = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t kind;
		pos_t  first;
		pos_t  past;
	} tok_t;

	// all tokens caused by one input beat
	typedef struct packed {
		tok_t [MAX_RES-1:0]  tok;
		logic [CNT_BITS-1:0] cnt;
	} grp_t;

	function automatic pos_t sat_inc(input pos_t p);
		return (&p) ? p : p + pos_t'(1);
	endfunction

	function automatic logic [31:0] low32(input pos_t p);
		logic [POS_BITS+31:0] ext;
		ext = {32'd0, p};
		return ext[31:0];
	endfunction

endpackage
`default_nettype wire

@@ design/kml_front.sv @@
// kml_front: accepts source beats, runs the scanner state machine and
// gathers the tokens of each beat into one group. Depends on kml_pkg.
`default_nettype none
module kml_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    char_code,
	input  wire logic          end_flag,
	output kml_pkg::grp_t      grp
);

	typedef enum logic [13:0] {
		M_IDLE       = 14'b00000000000001,
		M_HASH       = 14'b00000000000010,
		M_SIGN       = 14'b00000000000100,
		M_LINE       = 14'b00000000001000,
		M_BLOCK      = 14'b00000000010000,
		M_BLOCK_STAR = 14'b00000000100000,
		M_INT        = 14'b00000001000000,
		M_RADIX      = 14'b00000010000000,
		M_FRAC       = 14'b00000100000000,
		M_EXP        = 14'b00001000000000,
		M_EXP_DIGITS = 14'b00010000000000,
		M_IDENT      = 14'b00100000000000,
		M_KW_COLON   = 14'b01000000000000,
		M_KW_PART    = 14'b10000000000000
	} mode_t;

	mode_t         mode_q, nm;
	kml_pkg::pos_t pos_q, tb_q, kw_q, eb_q, ef_q, cb_q;
	kml_pkg::pos_t npos, ntb, nkw, neb, nef, ncb;
	logic          ep_q, nep;
	logic          fin, idl;
	logic          is_digit, is_sign, is_alpha, is_alnum, is_id_start, is_id_char;
	logic          is_e, is_r, is_eol, blk;
	kml_pkg::grp_t g;
	logic [7:0]    c;

	assign c           = char_code;
	assign is_digit    = (c >= 8'h30) && (c <= 8'h39);
	assign is_sign     = (c == 8'h2B) || (c == 8'h2D);
	assign is_alpha    = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	assign is_alnum    = is_alpha || is_digit;
	assign is_id_start = is_alpha || (c == kml_pkg::CH_UNDER);
	assign is_id_char  = is_id_start || is_digit;
	assign is_e        = (c == 8'h65) || (c == 8'h45);
	assign is_r        = (c == 8'h72) || (c == 8'h52);
	assign is_eol      = (c == 8'h0D) || (c == 8'h0A);
	assign blk         = (mode_q == M_BLOCK) || (mode_q == M_BLOCK_STAR);

	always_comb begin
		nm   = mode_q;
		npos = pos_q;
		ntb  = tb_q;
		nkw  = kw_q;
		neb  = eb_q;
		nef  = ef_q;
		nep  = ep_q;
		ncb  = cb_q;
		g    = '0;
		fin  = 1'b0;
		idl  = 1'b0;

		if (end_flag) begin
			fin = !blk;
		end else begin
			case (mode_q)
				M_HASH: begin
					if (c == kml_pkg::CH_HASH) begin
						nm = M_LINE;
					end else if (c == kml_pkg::CH_STAR) begin
						ncb = tb_q;
						nm  = M_BLOCK_STAR;
					end else begin
						fin = 1'b1;
					end
				end
				M_SIGN: begin
					if (is_digit) begin
						if (nep) begin
							g.tok[g.cnt].kind  = kml_pkg::K_ERROR;
							g.tok[g.cnt].first = neb;
							g.tok[g.cnt].past  = nef;
							g.cnt = g.cnt + 2'd1;
						end
						nep = 1'b0;
						nm  = M_INT;
					end else begin
						fin = 1'b1;
					end
				end
				M_LINE: begin
					if (is_eol) nm = M_IDLE;
				end
				M_BLOCK: begin
					if (c == kml_pkg::CH_STAR) nm = M_BLOCK_STAR;
				end
				M_BLOCK_STAR: begin
					if (c == kml_pkg::CH_HASH) nm = M_IDLE;
					else if (c != kml_pkg::CH_STAR) nm = M_BLOCK;
				end
				M_INT: begin
					if (is_digit) nm = M_INT;
					else if (is_r) nm = M_RADIX;
					else if (c == kml_pkg::CH_DOT) nm = M_FRAC;
					else if (is_e) nm = M_EXP;
					else fin = 1'b1;
				end
				M_RADIX: begin
					if (!is_alnum) fin = 1'b1;
				end
				M_FRAC: begin
					if (is_digit) nm = M_FRAC;
					else if (is_e) nm = M_EXP;
					else fin = 1'b1;
				end
				M_EXP: begin
					if (is_digit || is_sign) nm = M_EXP_DIGITS;
					else fin = 1'b1;
				end
				M_EXP_DIGITS: begin
					if (!is_digit) fin = 1'b1;
				end
				M_IDENT, M_KW_PART: begin
					if (is_id_char) begin
						nm = mode_q;
					end else if (c == kml_pkg::CH_COLON) begin
						nkw = kml_pkg::sat_inc(pos_q);
						nm  = M_KW_COLON;
					end else begin
						fin = 1'b1;
					end
				end
				M_KW_COLON: begin
					if (is_id_start) nm = M_KW_PART;
					else fin = 1'b1;
				end
				default: idl = 1'b1;
			endcase
		end

		// close the open token
		if (fin) begin
			case (mode_q)
				M_HASH, M_SIGN: begin
					if (!nep) begin
						neb = tb_q;
						nep = 1'b1;
					end
					nef = kml_pkg::sat_inc(tb_q);
				end
				M_INT, M_RADIX: begin
					g.tok[g.cnt].kind  = kml_pkg::K_INT;
					g.tok[g.cnt].first = tb_q;
					g.tok[g.cnt].past  = pos_q;
					g.cnt = g.cnt + 2'd1;
				end
				M_FRAC, M_EXP, M_EXP_DIGITS: begin
					g.tok[g.cnt].kind  = kml_pkg::K_FLOAT;
					g.tok[g.cnt].first = tb_q;
					g.tok[g.cnt].past  = pos_q;
					g.cnt = g.cnt + 2'd1;
				end
				M_IDENT: begin
					g.tok[g.cnt].kind  = kml_pkg::K_IDENT;
					g.tok[g.cnt].first = tb_q;
					g.tok[g.cnt].past  = pos_q;
					g.cnt = g.cnt + 2'd1;
				end
				M_KW_COLON: begin
					g.tok[g.cnt].kind  = kml_pkg::K_KEYWORD;
					g.tok[g.cnt].first = tb_q;
					g.tok[g.cnt].past  = kw_q;
					g.cnt = g.cnt + 2'd1;
				end
				M_KW_PART: begin
					g.tok[g.cnt].kind  = kml_pkg::K_KEYWORD;
					g.tok[g.cnt].first = tb_q;
					g.tok[g.cnt].past  = kw_q;
					g.cnt = g.cnt + 2'd1;
					g.tok[g.cnt].kind  = kml_pkg::K_IDENT;
					g.tok[g.cnt].first = kw_q;
					g.tok[g.cnt].past  = pos_q;
					g.cnt = g.cnt + 2'd1;
				end
				default: nm = M_IDLE;
			endcase
			nm = M_IDLE;
		end

		if (end_flag) begin
			if (nep) begin
				g.tok[g.cnt].kind  = kml_pkg::K_ERROR;
				g.tok[g.cnt].first = neb;
				g.tok[g.cnt].past  = nef;
				g.cnt = g.cnt + 2'd1;
			end
			if (blk && (g.cnt != 2'd3)) begin
				g.tok[g.cnt].kind  = kml_pkg::K_ERROR;
				g.tok[g.cnt].first = cb_q;
				g.tok[g.cnt].past  = pos_q;
				g.cnt = g.cnt + 2'd1;
			end
			// a beat carries at most three tokens; later ones are dropped
			if (g.cnt != 2'd3) begin
				g.tok[g.cnt].kind  = kml_pkg::K_EOS;
				g.tok[g.cnt].first = pos_q;
				g.tok[g.cnt].past  = pos_q;
				g.cnt = g.cnt + 2'd1;
			end
			nm   = M_IDLE;
			npos = '0;
			ntb  = '0;
			nkw  = '0;
			neb  = '0;
			nef  = '0;
			nep  = 1'b0;
			ncb  = '0;
		end else begin
			if (fin || idl) begin
				nm = M_IDLE;
				if (c > kml_pkg::CH_SPACE) begin
					if (c == kml_pkg::CH_HASH) begin
						ntb = pos_q;
						nm  = M_HASH;
					end else if (is_sign) begin
						ntb = pos_q;
						nm  = M_SIGN;
					end else if (is_digit || is_id_start) begin
						if (nep && (g.cnt != 2'd3)) begin
							g.tok[g.cnt].kind  = kml_pkg::K_ERROR;
							g.tok[g.cnt].first = neb;
							g.tok[g.cnt].past  = nef;
							g.cnt = g.cnt + 2'd1;
						end
						nep = 1'b0;
						ntb = pos_q;
						nm  = is_digit ? M_INT : M_IDENT;
					end else begin
						if (!nep) begin
							neb = pos_q;
							nep = 1'b1;
						end
						nef = kml_pkg::sat_inc(pos_q);
					end
				end
			end
			npos = kml_pkg::sat_inc(pos_q);
		end
	end

	assign grp = g;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q  <= '0;
			tb_q   <= '0;
			kw_q   <= '0;
			eb_q   <= '0;
			ef_q   <= '0;
			ep_q   <= 1'b0;
			cb_q   <= '0;
		end else if (accept) begin
			mode_q <= nm;
			pos_q  <= npos;
			tb_q   <= ntb;
			kw_q   <= nkw;
			eb_q   <= neb;
			ef_q   <= nef;
			ep_q   <= nep;
			cb_q   <= ncb;
		end
	end

endmodule
`default_nettype wire

@@ design/kml_queue.sv @@
// kml_queue: short FIFO of token groups between the scanner and the emitter.
// Depends on kml_pkg.
`default_nettype none
module kml_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire kml_pkg::grp_t wr_grp,
	input  wire logic          pop,
	output kml_pkg::grp_t      rd_grp,
	output logic               full,
	output logic               empty
);

	kml_pkg::grp_t              mem_q [kml_pkg::Q_DEPTH];
	logic [kml_pkg::Q_AW-1:0]  wr_q, rd_q;
	logic [kml_pkg::Q_CW-1:0]  cnt_q;

	assign full   = (cnt_q == kml_pkg::Q_CW'(kml_pkg::Q_DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_grp = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ design/kml_back.sv @@
// kml_back: walks the head group one token per cycle into the output
// register while the output is not stalled. Depends on kml_pkg.
`default_nettype none
module kml_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire kml_pkg::grp_t head,
	input  wire logic          empty,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [2:0]         token_kind,
	output logic [31:0]        token_start,
	output logic [31:0]        token_end,
	output logic               last_of_run
);

	logic [kml_pkg::CNT_BITS-1:0] idx_q;
	logic                         ov_q, load, at_last;
	kml_pkg::tok_t                cur;

	assign load    = !empty && (!ov_q || !out_stall);
	assign at_last = (idx_q == (head.cnt - 2'd1));
	assign cur     = head.tok[idx_q];
	assign pop     = load && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			if (load) idx_q <= at_last ? '0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			token_kind  <= cur.kind;
			token_start <= kml_pkg::low32(cur.first);
			token_end   <= kml_pkg::low32(cur.past);
			last_of_run <= at_last;
		end
	end

	assign out_valid = ov_q;

endmodule
`default_nettype wire

@@ design/keyword_message_lexer_top.sv @@
// A token is written from the beat that causes it into the group queue,
// then into the output register; a stall can hold it in the queue.
// One source beat per cycle while the queue is not full; a beat that causes
// k tokens sends them out one after another, absorbed by the 4-group queue.
// Reset (arst_n low, asynchronous): scanner between tokens at offset 0,
// queue empty, no output beat valid.
`default_nettype none
module keyword_message_lexer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_code,
	input  wire logic        end_flag,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       token_kind,
	output logic [31:0]      token_start,
	output logic [31:0]      token_end,
	output logic             last_of_run
);

	kml_pkg::grp_t grp, head;
	logic          accept, full, empty, pop;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	kml_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (char_code),
		.end_flag  (end_flag),
		.grp       (grp)
	);

	kml_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept && (grp.cnt != '0)),
		.wr_grp (grp),
		.pop    (pop),
		.rd_grp (head),
		.full   (full),
		.empty  (empty)
	);

	kml_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_kind  (token_kind),
		.token_start (token_start),
		.token_end   (token_end),
		.last_of_run (last_of_run)
	);

endmodule
`default_nettype wire

@@ design/kml_checker.sv @@
// kml_checker: port-level checks for keyword_message_lexer_top, bound in below.
// Depends on kml_pkg.
`default_nettype none
module kml_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [7:0]  char_code,
	input wire logic        end_flag,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  token_kind,
	input wire logic [31:0] token_start,
	input wire logic [31:0] token_end,
	input wire logic        last_of_run
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_start) && $stable(token_end))
		else $error("stalled output beat changed");

	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == kml_pkg::K_EOS) |-> last_of_run)
		else $error("end of source token not last of run");

	a_eos_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == kml_pkg::K_EOS) |-> (token_start == token_end))
		else $error("end of source token has nonzero length");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(char_code) && $stable(end_flag))
		else $error("stalled input beat changed");

	a_eos_new: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && (token_kind == kml_pkg::K_EOS) ##1
		out_valid && (token_kind != kml_pkg::K_EOS) && (token_kind != kml_pkg::K_ERROR)
		|-> (token_start < token_end))
		else $error("token after end of source is empty");

endmodule

bind keyword_message_lexer_top kml_checker u_chk (.*);
`default_nettype wire

@@ tb/sv/tb_keyword_message_lexer_top.sv @@
// Self-checking testbench for keyword_message_lexer_top: a queue-fed driver streams source
// bytes and end markers, an in-bench lexer predicts the tokens, a monitor checks every beat.
// Depends on kml_pkg (kind_t, character constants) and the keyword_message_lexer_top RTL.
`default_nettype none
module tb_keyword_message_lexer_top;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam string ID_START = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	localparam string ID_CHARS = "abcxyzAERrQZ_0123456789eE";
	localparam string ALNUM    = "0123456789abcdefxyzABCDEFXYZ";
	localparam string DIGITS   = "0123456789";
	localparam string SIGNS    = "+-";
	localparam string PUNCT    = "!$%&'()/;<=>?@[]^`{|}~,.\\\"";

	typedef enum logic [3:0] {
		SM_IDLE, SM_HASH, SM_SIGN, SM_LINE, SM_BLOCK, SM_BLOCK_STAR, SM_INT, SM_RADIX,
		SM_FRAC, SM_EXP, SM_EXP_DIGITS, SM_IDENT, SM_KW_COLON, SM_KW_PART
	} scan_mode_t;

	typedef struct {
		kml_pkg::kind_t kind;
		logic [31:0]    start_pos;
		logic [31:0]    end_pos;
		logic           last;
	} lex_token_t;

	typedef struct {
		logic [7:0] ch;
		logic       eos;
	} src_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  char_code = 8'd0;
	logic        end_flag = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  token_kind;
	logic [31:0] token_start;
	logic [31:0] token_end;
	logic        last_of_run;

	src_beat_t  source_beats[$];
	lex_token_t expected_tokens[$];
	lex_token_t step_tokens[$];

	int   cycle = 0;
	int   tokens_seen = 0;
	int   mismatches = 0;
	int   hold_left = 0;
	logic hold_done = 1'b0;
	wire  quiet = (cycle >= 400) && (cycle < 560);

	// lexer state
	scan_mode_t  mode;
	logic [31:0] pos, tok_begin, kw_end, err_begin, err_finish, cmt_begin;
	logic        err_pending;

	keyword_message_lexer_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.char_code(char_code), .end_flag(end_flag),
		.out_valid(out_valid), .out_stall(out_stall),
		.token_kind(token_kind), .token_start(token_start),
		.token_end(token_end), .last_of_run(last_of_run)
	);

	always #4 clk = ~clk;

	function automatic logic [31:0] pos_inc(input logic [31:0] p);
		return (&p) ? p : p + 32'd1;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_sign(input logic [7:0] c);
		return c == "+" || c == "-";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_id_start(input logic [7:0] c);
		return is_alpha(c) || c == kml_pkg::CH_UNDER;
	endfunction

	function automatic logic is_id_char(input logic [7:0] c);
		return is_id_start(c) || is_digit(c);
	endfunction

	task automatic lexer_clear();
		mode = SM_IDLE;
		pos = '0;
		tok_begin = '0;
		kw_end = '0;
		err_begin = '0;
		err_finish = '0;
		err_pending = 1'b0;
		cmt_begin = '0;
	endtask

	task automatic add_token(input kml_pkg::kind_t k, input logic [31:0] s,
		input logic [31:0] e);
		lex_token_t t;
		t.kind = k;
		t.start_pos = s;
		t.end_pos = e;
		t.last = 1'b0;
		step_tokens.insert(step_tokens.size(), t);
	endtask

	task automatic mark_error(input logic [31:0] p);
		if (!err_pending) begin
			err_begin = p;
			err_pending = 1'b1;
		end
		err_finish = pos_inc(p);
	endtask

	task automatic flush_error();
		if (err_pending)
			add_token(kml_pkg::K_ERROR, err_begin, err_finish);
		err_pending = 1'b0;
	endtask

	task automatic start_scan(input logic [7:0] c);
		mode = SM_IDLE;
		if (c > kml_pkg::CH_SPACE) begin
			if (c == kml_pkg::CH_HASH) begin
				tok_begin = pos;
				mode = SM_HASH;
			end else if (is_sign(c)) begin
				tok_begin = pos;
				mode = SM_SIGN;
			end else if (is_digit(c)) begin
				flush_error();
				tok_begin = pos;
				mode = SM_INT;
			end else if (is_id_start(c)) begin
				flush_error();
				tok_begin = pos;
				mode = SM_IDENT;
			end else begin
				mark_error(pos);
			end
		end
	endtask

	task automatic close_token();
		case (mode)
			SM_HASH, SM_SIGN: mark_error(tok_begin);
			SM_INT, SM_RADIX: add_token(kml_pkg::K_INT, tok_begin, pos);
			SM_FRAC, SM_EXP, SM_EXP_DIGITS: add_token(kml_pkg::K_FLOAT, tok_begin, pos);
			SM_IDENT: add_token(kml_pkg::K_IDENT, tok_begin, pos);
			SM_KW_COLON: add_token(kml_pkg::K_KEYWORD, tok_begin, kw_end);
			SM_KW_PART: begin
				add_token(kml_pkg::K_KEYWORD, tok_begin, kw_end);
				add_token(kml_pkg::K_IDENT, kw_end, pos);
			end
			default: ;
		endcase
		mode = SM_IDLE;
	endtask

	task automatic scan_char(input logic [7:0] c);
		case (mode)
			SM_HASH: begin
				if (c == kml_pkg::CH_HASH) mode = SM_LINE;
				else if (c == kml_pkg::CH_STAR) begin
					cmt_begin = tok_begin;
					mode = SM_BLOCK_STAR;
				end else begin
					mark_error(tok_begin);
					start_scan(c);
				end
			end
			SM_SIGN: begin
				if (is_digit(c)) begin
					flush_error();
					mode = SM_INT;
				end else begin
					mark_error(tok_begin);
					start_scan(c);
				end
			end
			SM_LINE: if (c == CH_CR || c == CH_LF) mode = SM_IDLE;
			SM_BLOCK: if (c == kml_pkg::CH_STAR) mode = SM_BLOCK_STAR;
			SM_BLOCK_STAR: begin
				if (c == kml_pkg::CH_HASH) mode = SM_IDLE;
				else if (c != kml_pkg::CH_STAR) mode = SM_BLOCK;
			end
			SM_INT: begin
				if (is_digit(c)) ;
				else if (c == "r" || c == "R") mode = SM_RADIX;
				else if (c == kml_pkg::CH_DOT) mode = SM_FRAC;
				else if (c == "e" || c == "E") mode = SM_EXP;
				else begin
					close_token();
					start_scan(c);
				end
			end
			SM_RADIX: begin
				if (!(is_alpha(c) || is_digit(c))) begin
					close_token();
					start_scan(c);
				end
			end
			SM_FRAC: begin
				if (is_digit(c)) ;
				else if (c == "e" || c == "E") mode = SM_EXP;
				else begin
					close_token();
					start_scan(c);
				end
			end
			SM_EXP: begin
				if (is_digit(c) || is_sign(c)) mode = SM_EXP_DIGITS;
				else begin
					close_token();
					start_scan(c);
				end
			end
			SM_EXP_DIGITS: begin
				if (!is_digit(c)) begin
					close_token();
					start_scan(c);
				end
			end
			SM_IDENT, SM_KW_PART: begin
				if (is_id_char(c)) ;
				else if (c == kml_pkg::CH_COLON) begin
					kw_end = pos_inc(pos);
					mode = SM_KW_COLON;
				end else begin
					close_token();
					start_scan(c);
				end
			end
			SM_KW_COLON: begin
				if (is_id_start(c)) mode = SM_KW_PART;
				else begin
					close_token();
					start_scan(c);
				end
			end
			default: start_scan(c);
		endcase
		pos = pos_inc(pos);
	endtask

	// tokens caused by one accepted beat, queued in source order
	task automatic lex_beat(input logic [7:0] c, input logic eos);
		lex_token_t t;
		step_tokens.delete();
		if (eos) begin
			if (mode == SM_BLOCK || mode == SM_BLOCK_STAR) begin
				flush_error();
				add_token(kml_pkg::K_ERROR, cmt_begin, pos);
			end else begin
				close_token();
				flush_error();
			end
			add_token(kml_pkg::K_EOS, pos, pos);
			lexer_clear();
		end else begin
			scan_char(c);
		end
		for (int i = 0; i < step_tokens.size(); i++) begin
			t = step_tokens[i];
			t.last = (i == step_tokens.size() - 1);
			expected_tokens.insert(expected_tokens.size(), t);
		end
	endtask

	// stimulus helpers
	function automatic logic [7:0] rnd_from(input string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	task automatic put(input logic [7:0] c);
		src_beat_t b;
		b.ch = c;
		b.eos = 1'b0;
		source_beats.insert(source_beats.size(), b);
	endtask

	task automatic add_eos();
		src_beat_t b;
		b.ch = 8'($urandom_range(255));
		b.eos = 1'b1;
		source_beats.insert(source_beats.size(), b);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	task automatic add_digits(input int n);
		repeat (n) put(rnd_from(DIGITS));
	endtask

	task automatic add_ident();
		put(rnd_from(ID_START));
		repeat ($urandom_range(3)) put(rnd_from(ID_CHARS));
	endtask

	task automatic add_piece();
		case ($urandom_range(11))
			0: add_ident();
			1: begin
				repeat ($urandom_range(1, 3)) begin
					add_ident();
					put(kml_pkg::CH_COLON);
				end
				if ($urandom_range(1)) add_ident();
			end
			2: begin
				if ($urandom_range(1)) put(rnd_from(SIGNS));
				add_digits($urandom_range(1, 4));
			end
			3: begin
				add_digits($urandom_range(1, 2));
				put($urandom_range(1) ? "r" : "R");
				repeat ($urandom_range(4)) put(rnd_from(ALNUM));
			end
			4: begin
				add_digits($urandom_range(1, 3));
				put(kml_pkg::CH_DOT);
				add_digits($urandom_range(3));
				if ($urandom_range(1)) begin
					put($urandom_range(1) ? "e" : "E");
					if ($urandom_range(1)) put(rnd_from(SIGNS));
					add_digits($urandom_range(2));
				end
			end
			5: begin
				add_digits($urandom_range(1, 2));
				put($urandom_range(1) ? "e" : "E");
				if ($urandom_range(2) == 0) put(rnd_from(SIGNS));
				add_digits($urandom_range(2));
			end
			6: begin
				add_text("##");
				repeat ($urandom_range(5)) put(8'($urandom_range(255)));
				put($urandom_range(1) ? CH_LF : CH_CR);
			end
			7: begin
				add_text("#*");
				repeat ($urandom_range(5))
					put($urandom_range(3) == 0 ? kml_pkg::CH_STAR : 8'($urandom_range(255)));
				add_text("*#");
			end
			8: repeat ($urandom_range(1, 3)) put(8'($urandom_range(32)));
			9: repeat ($urandom_range(1, 3))
				put($urandom_range(1) ? rnd_from(PUNCT) : 8'($urandom_range(128, 255)));
			10: begin
				put($urandom_range(1) ? kml_pkg::CH_HASH : rnd_from(SIGNS));
				put($urandom_range(1) ? rnd_from(ID_START) : rnd_from(PUNCT));
			end
			default: repeat ($urandom_range(1, 3)) put(8'($urandom_range(255)));
		endcase
		if ($urandom_range(3) != 0) put(8'($urandom_range(32)));
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin : drive
		src_beat_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			char_code <= 8'd0;
			end_flag <= 1'b0;
			lexer_clear();
		end else begin
			if (in_valid && !in_stall)
				lex_beat(char_code, end_flag);
			if (!in_valid || !in_stall) begin
				if (source_beats.size() > 0 && (quiet || $urandom_range(99) >= 17)) begin
					nxt = source_beats.pop_front();
					in_valid <= 1'b1;
					char_code <= nxt.ch;
					end_flag <= nxt.eos;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk)
		cycle <= cycle + 1;

	// long receiver hold-off so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && tokens_seen >= 40) begin
			hold_left <= 60;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= (hold_left != 0) || (!quiet && $urandom_range(99) < 17);
	end

	// receiver check
	always @(posedge clk) begin : check
		lex_token_t want;
		if (arst_n && out_valid && !out_stall) begin
			tokens_seen <= tokens_seen + 1;
			if (expected_tokens.size() == 0) begin
				$error("unexpected token: kind %0d start %0d end %0d", token_kind,
					token_start, token_end);
				mismatches++;
			end else begin
				want = expected_tokens.pop_front();
				if (token_kind !== want.kind) begin
					$error("token_kind: expected %0d, got %0d", want.kind, token_kind);
					mismatches++;
				end
				if (token_start !== want.start_pos) begin
					$error("token_start: expected %0d, got %0d", want.start_pos, token_start);
					mismatches++;
				end
				if (token_end !== want.end_pos) begin
					$error("token_end: expected %0d, got %0d", want.end_pos, token_end);
					mismatches++;
				end
				if (last_of_run !== want.last) begin
					$error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		int target;
		int src_len;
		int src_base;
		// whole block comment, unclosed block comment
		add_text("#*##*x");
		add_eos();
		// keyword with trailing part, float with signed exponent, error run,
		// lone sign and hash, line comment, high byte
		add_text("a:b:c-7e+3$+x#1.5##");
		put(CH_LF);
		put(8'hFF);
		add_eos();
		target = 370;
		while (source_beats.size() < target) begin
			src_len = $urandom_range(8, 40);
			src_base = source_beats.size();
			while (source_beats.size() - src_base < src_len)
				add_piece();
			add_eos();
		end

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (source_beats.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#1600000;
		$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire
